FILE: rtl/core/crcwfp_pkg.sv
`default_nettype none
// ----------------------------------------------------------------------------
// crcwfp_pkg: shared types, constants and function of the frame parser
// CRC-8 constants, byte phase codes within a group and the byte-wide CRC step.
// ----------------------------------------------------------------------------
package crcwfp_pkg;

    // CRC-8, polynomial x^8 + x^5 + x^4 + 1, MSB first, no final XOR
    localparam logic [7:0] CRC_INIT = 8'hFF;
    localparam logic [7:0] CRC_POLY = 8'h31;
    localparam logic [7:0] CRC_TOP  = 8'h80;

    // Frame layout: six groups of two data bytes and one check byte
    localparam int unsigned FRAME_WORDS = 6;
    localparam int unsigned WORD_IDX_W  = $clog2(FRAME_WORDS);
    localparam logic [WORD_IDX_W-1:0] LAST_WORD = WORD_IDX_W'(FRAME_WORDS - 1);

    localparam int unsigned BYTE_W   = 8;
    localparam int unsigned WORD_W   = 16;
    localparam int unsigned VALUE_W  = 32;
    localparam int unsigned RESULT_W = 3 * VALUE_W;

    // Position of a byte within its group
    typedef enum logic [1:0] {
        PH_HIGH  = 2'd0,
        PH_LOW   = 2'd1,
        PH_CHECK = 2'd2
    } phase_t;

    // One byte through the CRC, bit by bit
    function automatic logic [7:0] crc8_byte(input logic [7:0] crc, input logic [7:0] data);
        logic [7:0] v;
        v = crc ^ data;
        for (int k = 0; k < 8; k++)
        begin
            if ((v & CRC_TOP) != 8'h00)
                v = (v << 1) ^ CRC_POLY;
            else
                v = v << 1;
        end
        return v;
    endfunction

endpackage : crcwfp_pkg
`default_nettype wire

FILE: rtl/core/crc_checked_word_frame_parser_core.sv
`default_nettype none
// ----------------------------------------------------------------------------
// crc_checked_word_frame_parser_core: CRC-checked 18-byte measurement frame parser
// Collects six 16-bit words, checks each with CRC-8 and returns three 32-bit
// raw float patterns plus a mismatch flag once per complete frame.
// ----------------------------------------------------------------------------
//
//  Channel   | Direction | tdata                          | tuser
//  ----------+-----------+--------------------------------+----------------
//  s_axis    | in        | [7:0] data_byte                | [0] frame_start
//  m_axis    | out       | [31:0] co2, [63:32] temp,      | [0] frame_status
//            |           | [95:64] humidity               |
//
//  One byte a cycle while the result register is free or being taken: a byte
//  is taken into the input register, the CRC step and word collection then take
//  it into the frame state, and the 18th byte loads the result register, which
//  holds the result and the frame status until the output handshake takes it.
//  Reset clears the handshake valids and the frame position; words need none.
//  A full result register that is not taken holds the input register, and
//  s_axis_tready falls only when both stages are occupied.
// ----------------------------------------------------------------------------
module crc_checked_word_frame_parser_core
(
    input  wire logic        clk,
    input  wire logic        rst_n,

    input  wire logic        s_axis_tvalid,
    output logic             s_axis_tready,
    input  wire logic [7:0]  s_axis_tdata,   // [7:0] data_byte
    input  wire logic        s_axis_tuser,   // [0] frame_start

    output logic             m_axis_tvalid,
    input  wire logic        m_axis_tready,
    output logic [95:0]      m_axis_tdata,   // [31:0] co2_bits, [63:32] temperature_bits,
                                             // [95:64] humidity_bits
    output logic             m_axis_tuser    // [0] frame_status
);

    // Input register
    logic                                 in_valid_reg, in_valid_next;
    logic [crcwfp_pkg::BYTE_W-1:0]        in_byte_reg;
    logic                                 in_start_reg;

    // Frame state
    crcwfp_pkg::phase_t                   phase_reg, phase_next;
    logic [crcwfp_pkg::WORD_IDX_W-1:0]    word_reg, word_next;
    logic [7:0]                           crc_reg, crc_next;
    logic                                 mismatch_reg, mismatch_next;
    logic [crcwfp_pkg::BYTE_W-1:0]        hold_reg, hold_next;
    logic [crcwfp_pkg::WORD_W-1:0]        words_reg [crcwfp_pkg::FRAME_WORDS];

    // Result register
    logic                                 out_valid_reg, out_valid_next;
    logic [crcwfp_pkg::RESULT_W-1:0]      out_data_reg, out_data_next;
    logic                                 out_status_reg, out_status_next;

    // Working signals
    logic                                 proc_en;
    logic                                 take_in;
    crcwfp_pkg::phase_t                   cur_phase;
    logic [crcwfp_pkg::WORD_IDX_W-1:0]    cur_word;
    logic                                 frame_first;
    logic                                 frame_end;
    logic [7:0]                           crc_step;
    logic                                 mismatch_base;
    logic                                 check_fail;
    logic                                 word_wr_en;
    logic [crcwfp_pkg::WORD_W-1:0]        word_wr_data;

    // Handshake: the parse stage moves when the result slot is free or emptying
    assign proc_en       = in_valid_reg && (!out_valid_reg || m_axis_tready);
    assign s_axis_tready = !in_valid_reg || proc_en;
    assign take_in       = s_axis_tvalid && s_axis_tready;

    assign m_axis_tvalid = out_valid_reg;
    assign m_axis_tdata  = out_data_reg;
    assign m_axis_tuser  = out_status_reg;

    // Position of this byte; a start flag forces the first byte of a frame
    assign cur_phase   = in_start_reg ? crcwfp_pkg::PH_HIGH : phase_reg;
    assign cur_word    = in_start_reg ? '0 : word_reg;
    assign frame_first = (cur_phase == crcwfp_pkg::PH_HIGH) && (cur_word == '0);
    assign frame_end   = (cur_phase == crcwfp_pkg::PH_CHECK) &&
                         (cur_word == crcwfp_pkg::LAST_WORD);

    // CRC step: a group restarts from the initial value on its first byte
    assign crc_step = crcwfp_pkg::crc8_byte(
                          (cur_phase == crcwfp_pkg::PH_HIGH) ? crcwfp_pkg::CRC_INIT : crc_reg,
                          in_byte_reg);

    assign mismatch_base = frame_first ? 1'b0 : mismatch_reg;
    assign check_fail    = (crc_reg != in_byte_reg);

    // Parse logic
    always_comb
    begin
        phase_next    = phase_reg;
        word_next     = word_reg;
        crc_next      = crc_reg;
        mismatch_next = mismatch_reg;
        hold_next     = hold_reg;
        word_wr_en    = 1'b0;
        word_wr_data  = {hold_reg, in_byte_reg};

        if (proc_en)
        begin
            mismatch_next = mismatch_base;
            case (cur_phase)
                crcwfp_pkg::PH_HIGH:
                begin
                    crc_next   = crc_step;
                    hold_next  = in_byte_reg;
                    phase_next = crcwfp_pkg::PH_LOW;
                    word_next  = cur_word;
                end
                crcwfp_pkg::PH_LOW:
                begin
                    crc_next   = crc_step;
                    word_wr_en = 1'b1;
                    phase_next = crcwfp_pkg::PH_CHECK;
                    word_next  = cur_word;
                end
                crcwfp_pkg::PH_CHECK:
                begin
                    mismatch_next = mismatch_base | check_fail;
                    crc_next      = crcwfp_pkg::CRC_INIT;
                    phase_next    = crcwfp_pkg::PH_HIGH;
                    word_next     = frame_end ? '0 : cur_word + 1'b1;
                end
                default:
                begin
                    phase_next = crcwfp_pkg::PH_HIGH;
                    word_next  = '0;
                end
            endcase
            if (frame_end)
                mismatch_next = 1'b0;
        end
    end

    // Result register load
    always_comb
    begin
        out_valid_next  = out_valid_reg && !m_axis_tready;
        out_data_next   = out_data_reg;
        out_status_next = out_status_reg;
        if (proc_en && frame_end)
        begin
            out_valid_next  = 1'b1;
            out_data_next   = {words_reg[4], words_reg[5],
                               words_reg[2], words_reg[3],
                               words_reg[0], words_reg[1]};
            out_status_next = mismatch_base | check_fail;
        end
    end

    // Input register next valid
    always_comb
    begin
        in_valid_next = in_valid_reg;
        if (take_in)
            in_valid_next = 1'b1;
        else if (proc_en)
            in_valid_next = 1'b0;
    end

    // Control registers
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            in_valid_reg  <= 1'b0;
            out_valid_reg <= 1'b0;
            phase_reg     <= crcwfp_pkg::PH_HIGH;
            word_reg      <= '0;
            crc_reg       <= crcwfp_pkg::CRC_INIT;
            mismatch_reg  <= 1'b0;
        end
        else
        begin
            in_valid_reg  <= in_valid_next;
            out_valid_reg <= out_valid_next;
            phase_reg     <= phase_next;
            word_reg      <= word_next;
            crc_reg       <= crc_next;
            mismatch_reg  <= mismatch_next;
        end
    end

    // Payload registers
    always_ff @(posedge clk)
    begin
        if (take_in)
        begin
            in_byte_reg  <= s_axis_tdata;
            in_start_reg <= s_axis_tuser;
        end
        hold_reg       <= hold_next;
        out_data_reg   <= out_data_next;
        out_status_reg <= out_status_next;
    end

    // Collected words
    always_ff @(posedge clk)
    begin
        if (word_wr_en)
            words_reg[cur_word] <= word_wr_data;
    end

endmodule : crc_checked_word_frame_parser_core
`default_nettype wire
